### rtl/lfpd_pkg.sv
// Shared types and constants of the lidar frame point decoder.
`timescale 1ns / 1ps
package lfpd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HDR = 8'd1;

  localparam logic [3:0] FIRST_HDR_RESET  = 4'd10;
  localparam logic [3:0] SECOND_HDR_RESET = 4'd5;

  // Angles are in 1/64 degree.
  // The step turns negative when the previous start lies beyond a full turn,
  // so it is carried in two's complement.
  localparam int ANGLE_W = 15;
  localparam int DIFF_W  = 17;
  localparam logic [DIFF_W-1:0] FULL_TURN_Q6 = 17'd23040;

  // Frame store: one bank bit on top of the byte position.
  localparam int POS_W        = 8;
  localparam int STORE_ADDR_W = POS_W + 1;

  localparam int JOB_FIFO_DEPTH = 2;
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

  typedef struct packed {
    logic               bank;
    logic [ANGLE_W-1:0] start;
    logic [DIFF_W-1:0]  diff;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

  typedef struct packed {
    logic [15:0] angle_centideg;
    logic [15:0] distance_raw;
    logic [4:0]  point_number;
    logic        last_point;
  } point_t;

endpackage

### rtl/lfpd_fifo.sv
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
module lfpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/lfpd_frame_store.sv
// Two-bank frame byte memory with one write port and two registered read ports.
`timescale 1ns / 1ps
module lfpd_frame_store (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [lfpd_pkg::STORE_ADDR_W-1:0]   wr_addr,
  input  logic [7:0]                          wr_data,
  input  logic [lfpd_pkg::STORE_ADDR_W-1:0]   rd_addr_a,
  input  logic [lfpd_pkg::STORE_ADDR_W-1:0]   rd_addr_b,
  output logic [7:0]                          rd_data_a,
  output logic [7:0]                          rd_data_b
);
  import lfpd_pkg::*;

  logic [7:0] mem [2**STORE_ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### rtl/lfpd_front.sv
// Front end: header hunt, frame buffering, checksum and start angle step.
`timescale 1ns / 1ps
module lfpd_front #(
  parameter int FRAME_BYTES = 84
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic [7:0]                          in_rx_byte,
  output logic                                in_full,
  input  logic                                cfg_valid,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                st_wr_en,
  output logic [lfpd_pkg::STORE_ADDR_W-1:0]   st_wr_addr,
  output logic [7:0]                          st_wr_data,
  output logic                                job_push,
  output lfpd_pkg::job_t                      job,
  input  lfpd_pkg::bank_release_t             release_bank
);
  import lfpd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [3:0]         hdr0_r, hdr1_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         xor_r, xor_nxt;
  logic [3:0]         b0_nib_r, b0_nib_nxt;
  logic [3:0]         b1_nib_r, b1_nib_nxt;
  logic [ANGLE_W-1:0] start_r, start_nxt;
  logic [ANGLE_W-1:0] prev_r, prev_nxt;
  logic               bank_r, bank_nxt;
  logic [1:0]         busy_r, busy_nxt;
  logic               accept;
  logic [DIFF_W-1:0]  diff;

  // A bank stays locked until the back end has read every point of it.
  assign in_full = busy_r[bank_r];
  assign accept  = in_push && !in_full;

  assign st_wr_en   = accept && (pos_r > POS_W'(1));
  assign st_wr_addr = {bank_r, pos_r};
  assign st_wr_data = in_rx_byte;

  // Equal start angles count as a full turn.
  always_comb begin
    if (start_r > prev_r) begin
      diff = DIFF_W'(start_r) - DIFF_W'(prev_r);
    end else begin
      diff = DIFF_W'(start_r) + FULL_TURN_Q6 - DIFF_W'(prev_r);
    end
  end

  assign job.bank  = bank_r;
  assign job.start = start_r;
  assign job.diff  = diff;

  always_comb begin
    pos_nxt    = pos_r;
    xor_nxt    = xor_r;
    b0_nib_nxt = b0_nib_r;
    b1_nib_nxt = b1_nib_r;
    start_nxt  = start_r;
    prev_nxt   = prev_r;
    bank_nxt   = bank_r;
    busy_nxt   = busy_r;
    job_push   = 1'b0;
    if (release_bank.valid) begin
      busy_nxt[release_bank.bank] = 1'b0;
    end
    if (accept) begin
      if (pos_r == POS_W'(0)) begin
        if (in_rx_byte[7:4] == hdr0_r) begin
          b0_nib_nxt = in_rx_byte[3:0];
          pos_nxt    = POS_W'(1);
        end
      end else if (pos_r == POS_W'(1)) begin
        if (in_rx_byte[7:4] == hdr1_r) begin
          b1_nib_nxt = in_rx_byte[3:0];
          pos_nxt    = POS_W'(2);
        end else begin
          pos_nxt = '0;
        end
      end else if (pos_r == POS_W'(2)) begin
        xor_nxt        = in_rx_byte;
        start_nxt[7:0] = in_rx_byte;
        pos_nxt        = POS_W'(3);
      end else begin
        xor_nxt = xor_r ^ in_rx_byte;
        if (pos_r == POS_W'(3)) begin
          start_nxt[ANGLE_W-1:8] = in_rx_byte[6:0];
        end
        if (pos_r < LAST_POS) begin
          pos_nxt = pos_r + 1'b1;
        end else begin
          pos_nxt = '0;
          // The expected checksum is the two header low nibbles side by side.
          if (xor_nxt == {b1_nib_r, b0_nib_r}) begin
            job_push         = 1'b1;
            prev_nxt         = start_r;
            bank_nxt         = !bank_r;
            busy_nxt[bank_r] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr0_r  <= FIRST_HDR_RESET;
      hdr1_r  <= SECOND_HDR_RESET;
      pos_r   <= '0;
      xor_r   <= '0;
      prev_r  <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      if (cfg_valid && (cfg_index == CFG_FIRST_HDR)) begin
        hdr0_r <= cfg_data[3:0];
      end
      if (cfg_valid && (cfg_index == CFG_SECOND_HDR)) begin
        hdr1_r <= cfg_data[3:0];
      end
      pos_r  <= pos_nxt;
      xor_r  <= xor_nxt;
      prev_r <= prev_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_nib_r <= b0_nib_nxt;
    b1_nib_r <= b1_nib_nxt;
    start_r  <= start_nxt;
  end

endmodule

### rtl/lfpd_back.sv
// Back end: steps through the points of a checked frame and computes each angle.
`timescale 1ns / 1ps
module lfpd_back #(
  parameter int FRAME_BYTES      = 84,
  parameter int POINTS_PER_FRAME = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                job_empty,
  input  lfpd_pkg::job_t                      job,
  output logic                                job_pop,
  output logic [lfpd_pkg::STORE_ADDR_W-1:0]   rd_addr_lo,
  output logic [lfpd_pkg::STORE_ADDR_W-1:0]   rd_addr_hi,
  input  logic [7:0]                          rd_data_lo,
  input  logic [7:0]                          rd_data_hi,
  output lfpd_pkg::bank_release_t             release_bank,
  input  logic [lfpd_pkg::OUT_CNT_W-1:0]      out_count,
  output logic                                pt_push,
  output lfpd_pkg::point_t                    pt
);
  import lfpd_pkg::*;

  localparam int N     = POINTS_PER_FRAME;
  localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
  // Largest value of start * N + diff * i. A negative step never takes it
  // below minus this value, so one sign bit on top covers both directions.
  localparam int T_MAX = 32767 * N + 32767 * (N - 1);
  localparam int T_W   = $clog2(T_MAX + 1);
  localparam int Y_W   = T_W + 1;
  localparam int LIMIT = 23040 * N;
  // Reciprocal of N scaled by 2**Y_W; the estimate is low by at most one.
  localparam logic [Y_W:0] RECIP = (Y_W + 1)'((64'd1 << Y_W) / N);

  logic               active_r, active_nxt;
  logic               bank_r, bank_nxt;
  logic [DIFF_W-1:0]  diff_r, diff_nxt;
  logic [T_W:0]       t_r, t_nxt;
  logic [T_W-1:0]     t_mag;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               issue, last_issue;
  logic [8:0]         lo_off, hi_off;
  logic [OUT_CNT_W:0] occupancy;

  // Stage 1: wrapped angle, store read data arrives.
  logic               v1_r;
  logic [T_W-1:0]     tw1_r;
  logic [IDX_W-1:0]   idx1_r;
  logic               last1_r, zlo1_r, zhi1_r, neg1_r;
  // Stage 2: angle scaled to hundredths times N.
  logic               v2_r;
  logic [Y_W-1:0]     y2_r;
  logic [15:0]        dist2_r;
  logic [IDX_W-1:0]   idx2_r;
  logic               last2_r, neg2_r;
  // Stage 3: reciprocal product.
  logic               v3_r;
  logic [2*Y_W:0]     prod3_r;
  logic [Y_W-1:0]     y3_r;
  logic [15:0]        dist3_r;
  logic [IDX_W-1:0]   idx3_r;
  logic               last3_r, neg3_r;

  logic [T_W+4:0]     tw25;
  logic [Y_W-1:0]     qe, qn, rem, q;

  assign occupancy = (OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(v1_r)
                   + (OUT_CNT_W + 1)'(v2_r) + (OUT_CNT_W + 1)'(v3_r);
  assign issue      = active_r && (occupancy < (OUT_CNT_W + 1)'(OUT_FIFO_DEPTH));
  assign last_issue = issue && (idx_r == IDX_W'(N - 1));
  assign job_pop    = !active_r && !job_empty;

  assign release_bank.valid = last_issue;
  assign release_bank.bank  = bank_r;

  assign lo_off     = 9'({idx_r, 2'b00}) + 9'd4;
  assign hi_off     = lo_off + 9'd1;
  assign rd_addr_lo = {bank_r, lo_off[7:0]};
  assign rd_addr_hi = {bank_r, hi_off[7:0]};

  always_comb begin
    active_nxt = active_r;
    bank_nxt   = bank_r;
    diff_nxt   = diff_r;
    t_nxt      = t_r;
    idx_nxt    = idx_r;
    if (job_pop) begin
      active_nxt = 1'b1;
      bank_nxt   = job.bank;
      diff_nxt   = job.diff;
      t_nxt      = (T_W + 1)'(job.start * N);
      idx_nxt    = '0;
    end else if (issue) begin
      t_nxt   = t_r + (T_W + 1)'($signed(diff_r));
      idx_nxt = idx_r + 1'b1;
      if (last_issue) begin
        active_nxt = 1'b0;
      end
    end
  end

  assign t_mag = t_r[T_W-1:0];

  assign tw25 = (T_W + 5)'({tw1_r, 4'b0000}) + (T_W + 5)'({tw1_r, 3'b000})
              + (T_W + 5)'(tw1_r);

  // Fix up the reciprocal estimate with one compare, then saturate.
  always_comb begin
    qe  = prod3_r[2*Y_W-1:Y_W];
    qn  = Y_W'(qe * N);
    rem = y3_r - qn;
    q   = (rem >= Y_W'(N)) ? qe + 1'b1 : qe;
  end

  // A point whose angle went below zero wraps to a huge value and saturates.
  assign pt_push              = v3_r;
  assign pt.angle_centideg    = (neg3_r || (q > Y_W'(16'hFFFF))) ? 16'hFFFF : q[15:0];
  assign pt.distance_raw      = dist3_r;
  assign pt.point_number      = 5'(idx3_r);
  assign pt.last_point        = last3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      v1_r     <= issue;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    bank_r  <= bank_nxt;
    diff_r  <= diff_nxt;
    t_r     <= t_nxt;
    idx_r   <= idx_nxt;

    tw1_r   <= (t_mag > T_W'(LIMIT)) ? t_mag - T_W'(LIMIT) : t_mag;
    neg1_r  <= t_r[T_W];
    idx1_r  <= idx_r;
    last1_r <= (idx_r == IDX_W'(N - 1));
    // Bytes past the frame end read as zero.
    zlo1_r  <= (lo_off >= 9'(FRAME_BYTES));
    zhi1_r  <= (hi_off >= 9'(FRAME_BYTES));

    y2_r    <= tw25[T_W+4:4];
    dist2_r <= {(zhi1_r ? 8'h00 : rd_data_hi), (zlo1_r ? 8'h00 : rd_data_lo)};
    idx2_r  <= idx1_r;
    last2_r <= last1_r;
    neg2_r  <= neg1_r;

    prod3_r <= (2 * Y_W + 1)'(y2_r * RECIP);
    y3_r    <= y2_r;
    dist3_r <= dist2_r;
    idx3_r  <= idx2_r;
    last3_r <= last2_r;
    neg3_r  <= neg2_r;
  end

endmodule

### rtl/lidar_frame_point_decoder_core.sv
// Top level of the lidar frame point decoder.
// Every input byte is taken while a frame bank is free.
// A good frame's first point passes the job queue, the angle stages and the result
// queue; further points follow one per cycle while the result queue has room.
// The front stalls only while both frame banks still hold unread points.
// Synchronous active-low reset clears all control state and restores the
// header nibbles to 10 and 5; the frame store itself is not cleared.
`timescale 1ns / 1ps
module lidar_frame_point_decoder_core #(
  parameter int FRAME_BYTES      = 84,
  parameter int POINTS_PER_FRAME = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic [7:0]                        in_rx_byte,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [15:0]                       out_angle_centideg,
  output logic [15:0]                       out_distance_raw,
  output logic [4:0]                        out_point_number,
  output logic                              out_last_point,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lfpd_pkg::*;

  logic                    st_wr_en;
  logic [STORE_ADDR_W-1:0] st_wr_addr;
  logic [7:0]              st_wr_data;
  logic [STORE_ADDR_W-1:0] rd_addr_lo, rd_addr_hi;
  logic [7:0]              rd_data_lo, rd_data_hi;
  logic                    job_push, job_pop, job_full, job_empty;
  logic [$clog2(JOB_FIFO_DEPTH+1)-1:0] job_count;
  job_t                    job_in, job_out;
  bank_release_t           release_bank;
  logic                    pt_push, out_full;
  point_t                  pt_in, pt_out;
  logic [OUT_CNT_W-1:0]    out_count;

  assign cfg_ready = 1'b1;

  lfpd_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_rx_byte   (in_rx_byte),
    .in_full      (in_full),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .st_wr_en     (st_wr_en),
    .st_wr_addr   (st_wr_addr),
    .st_wr_data   (st_wr_data),
    .job_push     (job_push),
    .job          (job_in),
    .release_bank (release_bank)
  );

  lfpd_frame_store u_store (
    .clk       (clk),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_data   (st_wr_data),
    .rd_addr_a (rd_addr_lo),
    .rd_addr_b (rd_addr_hi),
    .rd_data_a (rd_data_lo),
    .rd_data_b (rd_data_hi)
  );

  lfpd_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_in),
    .pop     (job_pop),
    .rd_data (job_out),
    .full    (job_full),
    .empty   (job_empty),
    .count   (job_count)
  );

  lfpd_back #(
    .FRAME_BYTES      (FRAME_BYTES),
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_empty    (job_empty),
    .job          (job_out),
    .job_pop      (job_pop),
    .rd_addr_lo   (rd_addr_lo),
    .rd_addr_hi   (rd_addr_hi),
    .rd_data_lo   (rd_data_lo),
    .rd_data_hi   (rd_data_hi),
    .release_bank (release_bank),
    .out_count    (out_count),
    .pt_push      (pt_push),
    .pt           (pt_in)
  );

  lfpd_fifo #(
    .WIDTH ($bits(point_t)),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (pt_push),
    .wr_data (pt_in),
    .pop     (out_pop),
    .rd_data (pt_out),
    .full    (out_full),
    .empty   (out_empty),
    .count   (out_count)
  );

  assign out_angle_centideg = pt_out.angle_centideg;
  assign out_distance_raw   = pt_out.distance_raw;
  assign out_point_number   = pt_out.point_number;
  assign out_last_point     = pt_out.last_point;

  // The credit check in the back end must keep the result queue from overflowing.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pt_push |-> !out_full)
    else $error("point pushed into a full result queue");

  // Two banks bound the number of queued frames.
  a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("frame job pushed into a full job queue");

  // The back end only takes a frame job that is really queued.
  a_job_pop_queued: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (job_count != '0))
    else $error("frame job taken from an empty job queue");

  // The final point of a frame always carries the last point number.
  a_last_number: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_point) |-> (out_point_number == 5'(POINTS_PER_FRAME - 1)))
    else $error("last point flag on a wrong point number");

  // A released bank must not be the one the front end is just locking.
  a_release_push: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && release_bank.valid) |-> (release_bank.bank != job_in.bank))
    else $error("bank released and locked in the same cycle");

endmodule
